>>> rtl/amns_pkg.sv
// shared constants and request codes for the adjacency matrix neighbor scan
package amns_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int REQ_TYPE_W = 2;
  localparam int VERTEX_W   = 4;
  localparam int WEIGHT_W   = 16;
  localparam int COUNT_W    = 5;

  localparam logic [REQ_TYPE_W-1:0] REQ_CONNECT = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_START   = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_NEXT    = 2'd2;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

endpackage

>>> rtl/amns_req_if.sv
// request channel: valid/ready handshake with the request payload
interface amns_req_if;
  import amns_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [REQ_TYPE_W-1:0]        req_type;
  logic [VERTEX_W-1:0]          vertex_a;
  logic [VERTEX_W-1:0]          vertex_b;
  logic signed [WEIGHT_W-1:0]   edge_weight;

  modport source (output valid, req_type, vertex_a, vertex_b, edge_weight, input ready);
  modport sink (input valid, req_type, vertex_a, vertex_b, edge_weight, output ready);
endinterface

>>> rtl/amns_rsp_if.sv
// response channel: valid/ready handshake with the result payload
interface amns_rsp_if;
  import amns_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [VERTEX_W-1:0]          neighbor_index;
  logic signed [WEIGHT_W-1:0]   neighbor_weight;

  modport source (output valid, status, neighbor_index, neighbor_weight, input ready);
  modport sink (input valid, status, neighbor_index, neighbor_weight, output ready);
endinterface

>>> rtl/amns_row_mem.sv
// row-wide adjacency memory with per-row valid bits and registered read
module amns_row_mem #(
  parameter int ROWS  = 16,
  parameter int ROW_W = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(ROWS)-1:0]  rd_addr,
  output logic [ROW_W-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(ROWS)-1:0]  wr_addr,
  input  logic [ROW_W-1:0]         wr_data
);

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_vld;
  logic [ROW_W-1:0] data_q;
  logic             vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      data_q <= mem[rd_addr];
    end
  end

  // a row never written since reset reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (rd_en) begin
        vld_q <= row_vld[rd_addr];
      end
      if (wr_en) begin
        row_vld[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = vld_q ? data_q : '0;

endmodule

>>> rtl/amns_ctrl.sv
// request sequencer: row read-modify-write, neighbor scan and result register
module amns_ctrl #(
  parameter int MAX_VERTICES = 16,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [amns_pkg::COUNT_W-1:0]          vertex_count,
  amns_req_if.sink                              req,
  amns_rsp_if.source                            rsp,
  output logic                                  mem_rd_en,
  output logic [$clog2(MAX_VERTICES)-1:0]       mem_rd_addr,
  input  logic [MAX_VERTICES*WEIGHT_BITS-1:0]   mem_rd_data,
  output logic                                  mem_wr_en,
  output logic [$clog2(MAX_VERTICES)-1:0]       mem_wr_addr,
  output logic [MAX_VERTICES*WEIGHT_BITS-1:0]   mem_wr_data
);
  import amns_pkg::*;

  localparam int RW    = $clog2(MAX_VERTICES);
  localparam int PW    = $clog2(MAX_VERTICES + 1);
  localparam int ROW_W = MAX_VERTICES * WEIGHT_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD_A = 3'd1;
  localparam logic [2:0] S_RD_B = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  typedef struct packed {
    logic                       status;
    logic [VERTEX_W-1:0]        neighbor_index;
    logic signed [WEIGHT_W-1:0] neighbor_weight;
  } result_t;

  logic [2:0]             state, state_next;
  logic [VERTEX_W-1:0]    req_a, req_b;
  logic [WEIGHT_BITS-1:0] req_w;
  logic                   scan_active;
  logic [RW-1:0]          scan_vertex;
  logic [PW-1:0]          scan_pos;
  result_t                res_now, res_pend, out_res;
  logic                   out_valid, out_free, out_load, produce, req_fire;
  logic [PW-1:0]          cnt;
  logic                   a_ok, b_ok;
  logic [MAX_VERTICES-1:0] cand, hit_oh;
  logic                   found;
  logic [RW-1:0]          hit_idx;
  logic [WEIGHT_BITS-1:0] hit_w;
  logic [ROW_W-1:0]       row_mod;

  // effective vertex count saturates at the matrix size
  always_comb begin
    if (int'(vertex_count) > MAX_VERTICES) begin
      cnt = PW'(MAX_VERTICES);
    end else begin
      cnt = PW'(vertex_count);
    end
  end

  assign a_ok      = int'(req.vertex_a) < int'(cnt);
  assign b_ok      = int'(req.vertex_b) < int'(cnt);
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  // first nonzero entry at or after the scan position and below the count
  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      cand[j] = (|mem_rd_data[j*WEIGHT_BITS +: WEIGHT_BITS]) &&
                (j >= int'(scan_pos)) && (j < int'(cnt));
    end
    hit_oh  = cand & (~cand + MAX_VERTICES'(1));
    found   = |cand;
    hit_idx = '0;
    hit_w   = '0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if (hit_oh[j]) begin
        hit_idx = hit_idx | RW'(j);
        hit_w   = hit_w | mem_rd_data[j*WEIGHT_BITS +: WEIGHT_BITS];
      end
    end
  end

  // patch one column of the row just read
  always_comb begin
    row_mod = mem_rd_data;
    if (state == S_RD_A) begin
      row_mod[RW'(req_b)*WEIGHT_BITS +: WEIGHT_BITS] = req_w;
    end else begin
      row_mod[RW'(req_a)*WEIGHT_BITS +: WEIGHT_BITS] = req_w;
    end
  end

  assign mem_wr_data = row_mod;

  always_comb begin
    state_next  = state;
    produce     = 1'b0;
    res_now     = '{status: STATUS_FAIL, neighbor_index: '0, neighbor_weight: '0};
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          case (req.req_type)
            REQ_CONNECT: begin
              if (a_ok && b_ok) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = RW'(req.vertex_a);
                state_next  = S_RD_A;
              end else begin
                produce = 1'b1;
              end
            end
            REQ_START: begin
              produce = 1'b1;
              if (a_ok) begin
                res_now.status = STATUS_OK;
              end
            end
            REQ_NEXT: begin
              if (scan_active) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = scan_vertex;
                state_next  = S_SCAN;
              end else begin
                produce = 1'b1;
              end
            end
            default: begin
              produce = 1'b1;
            end
          endcase
        end
      end
      S_RD_A: begin
        // write row a, fetch row b; a self loop rewrites the same entry
        mem_wr_en   = 1'b1;
        mem_wr_addr = RW'(req_a);
        mem_rd_en   = 1'b1;
        mem_rd_addr = RW'(req_b);
        state_next  = S_RD_B;
      end
      S_RD_B: begin
        mem_wr_en      = 1'b1;
        mem_wr_addr    = RW'(req_b);
        produce        = 1'b1;
        res_now.status = STATUS_OK;
      end
      S_SCAN: begin
        produce = 1'b1;
        if (found) begin
          res_now.status          = STATUS_OK;
          res_now.neighbor_index  = VERTEX_W'(hit_idx);
          res_now.neighbor_weight = WEIGHT_W'($signed(hit_w));
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (produce) begin
      state_next = out_free ? S_IDLE : S_OUT;
    end
  end

  assign out_load = (produce || (state == S_OUT)) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      scan_active <= 1'b0;
      scan_vertex <= '0;
      scan_pos    <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (req_fire && (req.req_type == REQ_START) && a_ok) begin
        scan_active <= 1'b1;
        scan_vertex <= RW'(req.vertex_a);
        scan_pos    <= '0;
      end else if (state == S_SCAN) begin
        if (found) begin
          scan_pos <= PW'(hit_idx) + PW'(1);
        end else begin
          scan_active <= 1'b0;
          scan_vertex <= '0;
          scan_pos    <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_a <= req.vertex_a;
      req_b <= req.vertex_b;
      req_w <= WEIGHT_BITS'(req.edge_weight);
    end
    if (produce && !out_free) begin
      res_pend <= res_now;
    end
    if (out_load) begin
      out_res <= (state == S_OUT) ? res_pend : res_now;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_res.status;
  assign rsp.neighbor_index  = out_res.neighbor_index;
  assign rsp.neighbor_weight = out_res.neighbor_weight;

endmodule

>>> rtl/adjacency_matrix_neighbor_scan.sv
// start, rejected and unknown requests answered from idle; next-neighbor reads and scans the row
// one transaction at a time, a new one accepted once the sequencer is idle;
//   connect takes two row read-modify-writes through the single memory read port
// a finished result waits in the output register while the next transaction is taken
// reset clears the row valid bits (matrix reads as zero) and scan state, vertex count back to 16
// top level: vertex count register, adjacency row memory and request sequencer
module adjacency_matrix_neighbor_scan #(
  parameter int MAX_VERTICES = amns_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = amns_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [amns_pkg::COUNT_W-1:0]  cfg_wr_data,
  amns_req_if.sink                      req,
  amns_rsp_if.source                    rsp
);
  import amns_pkg::*;

  localparam int RW    = $clog2(MAX_VERTICES);
  localparam int ROW_W = MAX_VERTICES * WEIGHT_BITS;

  logic [COUNT_W-1:0] vertex_count;
  logic               mem_rd_en, mem_wr_en;
  logic [RW-1:0]      mem_rd_addr, mem_wr_addr;
  logic [ROW_W-1:0]   mem_rd_data, mem_wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  amns_row_mem #(
    .ROWS  (MAX_VERTICES),
    .ROW_W (ROW_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  amns_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .vertex_count (vertex_count),
    .req          (req),
    .rsp          (rsp),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data)
  );

endmodule

>>> rtl/amns_checker.sv
// port-level assertions for the neighbor scan block and their bind
module amns_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic                               rsp_status,
  input logic [amns_pkg::VERTEX_W-1:0]      rsp_neighbor_index,
  input logic [amns_pkg::WEIGHT_W-1:0]      rsp_neighbor_weight
);
  import amns_pkg::*;

  logic [1:0] outstanding;
  logic       req_fire, rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // transactions taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (req_fire && !rsp_fire) begin
      outstanding <= outstanding + 2'd1;
    end else if (rsp_fire && !req_fire) begin
      outstanding <= outstanding - 2'd1;
    end
  end

  a_fail_zero_payload: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STATUS_FAIL) |->
      (rsp_neighbor_index == '0) && (rsp_neighbor_weight == '0))
    else $error("failed result carries a nonzero payload");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (outstanding != 2'd0))
    else $error("result shown with no transaction outstanding");

  a_bounded_in_flight: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("more than two transactions in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn before it was taken");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind adjacency_matrix_neighbor_scan amns_checker u_amns_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_status          (rsp.status),
  .rsp_neighbor_index  (rsp.neighbor_index),
  .rsp_neighbor_weight (rsp.neighbor_weight)
);

>>> bench/adjacency_matrix_neighbor_scan_test.sv
// testbench for the adjacency matrix neighbor scan: directed table, random phases, scoreboard
module adjacency_matrix_neighbor_scan_test;
  import amns_pkg::*;

  localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int GRAPH_SIZE       = MAX_VERTICES_DEF;
  localparam int LIMIT_CYCLES     = 400000;
  localparam int SETTLE_CYCLES    = 4;
  localparam int HOLD_CYCLES      = 400;
  localparam int ITEMS_PER_PHASE  = 114;
  localparam int NUM_PHASES       = 12;

  typedef struct packed {
    logic                       status;
    logic [VERTEX_W-1:0]        index;
    logic signed [WEIGHT_W-1:0] weight;
  } scan_result_t;

  typedef struct packed {
    logic                       set_count;
    logic [COUNT_W-1:0]         count;
    logic [REQ_TYPE_W-1:0]      kind;
    logic [VERTEX_W-1:0]        a;
    logic [VERTEX_W-1:0]        b;
    logic signed [WEIGHT_W-1:0] w;
    logic                       typed;
    scan_result_t               want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;

  // sideband carried with each request: a typed-in result replaces the prediction
  logic         row_typed = 1'b0;
  scan_result_t row_want = '0;

  amns_req_if req_ch ();
  amns_rsp_if rsp_ch ();

  adjacency_matrix_neighbor_scan uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  // graph model state
  logic signed [WEIGHT_W-1:0] graph_adj [GRAPH_SIZE][GRAPH_SIZE];
  logic [COUNT_W-1:0]         graph_count;
  logic                       scan_on;
  logic [VERTEX_W-1:0]        scan_row;
  int                         scan_pos;

  scan_result_t pending_results [$];
  int           mismatches = 0;
  int           cycle_count = 0;

  // stimulus controls
  bit                 sender_idle = 1'b1;
  bit                 receiver_idle = 1'b1;
  bit                 hold_req = 1'b0;
  logic [COUNT_W-1:0] cur_count = VERTEX_COUNT_RESET;
  script_row_t        directed_rows [$];

  always #5 clk = ~clk;

  function automatic scan_result_t graph_apply_request(logic [REQ_TYPE_W-1:0] kind,
                                                       logic [VERTEX_W-1:0] a,
                                                       logic [VERTEX_W-1:0] b,
                                                       logic signed [WEIGHT_W-1:0] w);
    scan_result_t r;
    int lim;
    int pos;
    bit found;
    r = '{STATUS_FAIL, '0, '0};
    lim = (graph_count > GRAPH_SIZE) ? GRAPH_SIZE : int'(graph_count);
    case (kind)
      REQ_CONNECT: begin
        if (a < lim && b < lim) begin
          graph_adj[a][b] = w;
          graph_adj[b][a] = w;
          r.status = STATUS_OK;
        end
      end
      REQ_START: begin
        if (a < lim) begin
          scan_on = 1'b1;
          scan_row = a;
          scan_pos = 0;
          r.status = STATUS_OK;
        end
      end
      REQ_NEXT: begin
        if (scan_on) begin
          pos = scan_pos;
          found = 1'b0;
          while (pos < lim && !found) begin
            if (graph_adj[scan_row][pos] != 0) found = 1'b1;
            else pos++;
          end
          if (found) begin
            r.status = STATUS_OK;
            r.index = pos[VERTEX_W-1:0];
            r.weight = graph_adj[scan_row][pos];
            scan_pos = pos + 1;
          end else begin
            // row exhausted: the scan drops back to idle
            scan_on = 1'b0;
            scan_row = '0;
            scan_pos = 0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    scan_result_t res;
    scan_result_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
    if (!rst) begin
      if (cfg_wr_en) graph_count = cfg_wr_data;
      if (req_ch.valid && req_ch.ready) begin
        res = graph_apply_request(req_ch.req_type, req_ch.vertex_a, req_ch.vertex_b,
                                  req_ch.edge_weight);
        pending_results.push_back(row_typed ? row_want : res);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: status %0d index %0d weight %0d",
                   $time, rsp_ch.status, rsp_ch.neighbor_index, rsp_ch.neighbor_weight);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     rsp_ch.status);
            mismatches++;
          end
          if (rsp_ch.neighbor_index !== want.index) begin
            $display("%0t: neighbor_index expected %0d actual %0d", $time, want.index,
                     rsp_ch.neighbor_index);
            mismatches++;
          end
          if (rsp_ch.neighbor_weight !== want.weight) begin
            $display("%0t: neighbor_weight expected %0d actual %0d", $time, want.weight,
                     rsp_ch.neighbor_weight);
            mismatches++;
          end
        end
      end
    end
  end

  // response side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      gap = receiver_idle ? $urandom_range(0, 19) : 0;
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  function automatic script_row_t req_row(logic [REQ_TYPE_W-1:0] kind, logic [VERTEX_W-1:0] a,
                                          logic [VERTEX_W-1:0] b,
                                          logic signed [WEIGHT_W-1:0] w);
    script_row_t r;
    r = '0;
    r.kind = kind;
    r.a = a;
    r.b = b;
    r.w = w;
    return r;
  endfunction

  function automatic script_row_t typed_row(logic [REQ_TYPE_W-1:0] kind,
                                            logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b,
                                            logic signed [WEIGHT_W-1:0] w, logic st,
                                            logic [VERTEX_W-1:0] idx,
                                            logic signed [WEIGHT_W-1:0] wt);
    script_row_t r;
    r = req_row(kind, a, b, w);
    r.typed = 1'b1;
    r.want = '{st, idx, wt};
    return r;
  endfunction

  function automatic script_row_t count_row(logic [COUNT_W-1:0] count);
    script_row_t r;
    r = '0;
    r.set_count = 1'b1;
    r.count = count;
    return r;
  endfunction

  function automatic logic [VERTEX_W-1:0] pick_vertex(int lim);
    if (lim > 0 && $urandom_range(0, 7) != 0) return VERTEX_W'($urandom_range(0, lim - 1));
    return VERTEX_W'($urandom_range(0, GRAPH_SIZE - 1));
  endfunction

  function automatic logic [VERTEX_W-1:0] rand_vertex();
    return VERTEX_W'($urandom);
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] rand_weight();
    return WEIGHT_W'($urandom);
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 15))
      0, 1: return '0;
      2: return 16'sh8000;
      3: return 16'sh7fff;
      4: return -16'sd1;
      default: return rand_weight();
    endcase
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (pending_results.size() != 0);
    @(posedge clk);
  endtask

  task automatic send_request(logic [REQ_TYPE_W-1:0] kind, logic [VERTEX_W-1:0] a,
                              logic [VERTEX_W-1:0] b, logic signed [WEIGHT_W-1:0] w,
                              logic typed, scan_result_t want);
    int gap;
    gap = sender_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.req_type <= kind;
    req_ch.vertex_a <= a;
    req_ch.vertex_b <= b;
    req_ch.edge_weight <= w;
    row_typed <= typed;
    row_want <= want;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
  endtask

  // only while idle: nothing in flight and the sequencer has settled
  task automatic write_vertex_count(logic [COUNT_W-1:0] count);
    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= count;
    cur_count = count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drive_random_phase(int n);
    int lim;
    int sent;
    int r;
    int k;
    lim = (cur_count > GRAPH_SIZE) ? GRAPH_SIZE : int'(cur_count);
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_request(REQ_CONNECT, pick_vertex(lim), pick_vertex(lim), pick_weight(), 1'b0, '0);
        sent++;
      end else if (r < 48) begin
        send_request(REQ_START, pick_vertex(lim), rand_vertex(), rand_weight(), 1'b0, '0);
        sent++;
      end else if (r < 52) begin
        // unused request type, answered with a fail; does not count toward the phase
        send_request(REQ_UNUSED, rand_vertex(), rand_vertex(), rand_weight(), 1'b0, '0);
      end else if (r < 56) begin
        send_request(REQ_NEXT, rand_vertex(), rand_vertex(), rand_weight(), 1'b0, '0);
        sent++;
      end else begin
        // full scan: start then walk the row, usually past its end
        send_request(REQ_START, pick_vertex(lim), rand_vertex(), rand_weight(), 1'b0, '0);
        k = $urandom_range(1, lim + 2);
        repeat (k) send_request(REQ_NEXT, rand_vertex(), rand_vertex(), rand_weight(),
                                1'b0, '0);
        sent += k + 1;
      end
    end
  endtask

  initial begin
    int phase_counts [NUM_PHASES];
    phase_counts = '{16, 1, 0, 31, 5, 12, 16, 2, 17, 9, 16, 3};
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_CONNECT;
    req_ch.vertex_a = '0;
    req_ch.vertex_b = '0;
    req_ch.edge_weight = '0;
    foreach (graph_adj[i, j]) graph_adj[i][j] = '0;
    graph_count = VERTEX_COUNT_RESET;
    scan_on = 1'b0;
    scan_row = '0;
    scan_pos = 0;

    directed_rows.push_back(typed_row(REQ_NEXT, 0, 0, 0, STATUS_FAIL, 0, 0));
    directed_rows.push_back(typed_row(REQ_START, 15, 0, 0, STATUS_OK, 0, 0));
    directed_rows.push_back(typed_row(REQ_NEXT, 0, 0, 0, STATUS_FAIL, 0, 0));
    directed_rows.push_back(typed_row(REQ_CONNECT, 0, 15, 16'sh8000, STATUS_OK, 0, 0));
    directed_rows.push_back(typed_row(REQ_CONNECT, 15, 15, 16'sh7fff, STATUS_OK, 0, 0));
    directed_rows.push_back(typed_row(REQ_START, 15, 0, 0, STATUS_OK, 0, 0));
    directed_rows.push_back(typed_row(REQ_NEXT, 0, 0, 0, STATUS_OK, 0, 16'sh8000));
    directed_rows.push_back(typed_row(REQ_NEXT, 0, 0, 0, STATUS_OK, 15, 16'sh7fff));
    directed_rows.push_back(typed_row(REQ_NEXT, 0, 0, 0, STATUS_FAIL, 0, 0));
    directed_rows.push_back(typed_row(REQ_NEXT, 0, 0, 0, STATUS_FAIL, 0, 0));
    directed_rows.push_back(typed_row(REQ_UNUSED, 15, 15, -16'sd1, STATUS_FAIL, 0, 0));
    directed_rows.push_back(req_row(REQ_CONNECT, 7, 9, -16'sd1));
    directed_rows.push_back(count_row(5'd4));
    directed_rows.push_back(typed_row(REQ_CONNECT, 3, 4, 16'sd5, STATUS_FAIL, 0, 0));
    directed_rows.push_back(typed_row(REQ_START, 4, 0, 0, STATUS_FAIL, 0, 0));
    directed_rows.push_back(typed_row(REQ_START, 3, 0, 0, STATUS_OK, 0, 0));
    directed_rows.push_back(typed_row(REQ_CONNECT, 15, 15, 16'sd1, STATUS_FAIL, 0, 0));
    directed_rows.push_back(count_row(5'd0));
    directed_rows.push_back(typed_row(REQ_START, 0, 0, 0, STATUS_FAIL, 0, 0));
    directed_rows.push_back(typed_row(REQ_CONNECT, 0, 0, 16'sd1, STATUS_FAIL, 0, 0));
    directed_rows.push_back(req_row(REQ_NEXT, 0, 0, 0));
    directed_rows.push_back(count_row(5'd31));
    directed_rows.push_back(typed_row(REQ_START, 9, 0, 0, STATUS_OK, 0, 0));
    directed_rows.push_back(req_row(REQ_CONNECT, 9, 14, 16'sd2));
    // count lowered while the scan of row 9 is running
    directed_rows.push_back(count_row(5'd8));
    directed_rows.push_back(req_row(REQ_NEXT, 0, 0, 0));
    directed_rows.push_back(req_row(REQ_NEXT, 0, 0, 0));
    directed_rows.push_back(count_row(5'd16));
    directed_rows.push_back(typed_row(REQ_CONNECT, 0, 15, 16'sd0, STATUS_OK, 0, 0));
    directed_rows.push_back(typed_row(REQ_START, 0, 0, 0, STATUS_OK, 0, 0));
    directed_rows.push_back(req_row(REQ_NEXT, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_count) write_vertex_count(directed_rows[i].count);
      else send_request(directed_rows[i].kind, directed_rows[i].a, directed_rows[i].b,
                        directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_vertex_count(COUNT_W'(phase_counts[p]));
      sender_idle = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      if (p == 1) begin
        // long response stall while requests keep coming back to back
        hold_req = 1'b1;
        sender_idle = 1'b0;
      end
      drive_random_phase(ITEMS_PER_PHASE);
    end

    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
